[design/online_mean_variance_macros.svh]
// Assertion macros for the online mean/variance block.
// Used by the port-level checker; no other dependencies.
`ifndef ONLINE_MEAN_VARIANCE_MACROS_SVH
`define ONLINE_MEAN_VARIANCE_MACROS_SVH

// same-cycle implication, disabled during reset
`define OMV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("omv assertion failed");

// next-cycle implication, disabled during reset
`define OMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("omv assertion failed");

// same-cycle implication that is also checked during reset
`define OMV_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("omv assertion failed");

`endif

[design/omv_pkg.sv]
// Package for the online mean/variance block: widths, request/response
// structs and the sequencer state type. No dependencies.
`default_nettype none

package omv_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int FRAC_BITS    = 16;
   localparam int COUNT_WIDTH  = 20;
   localparam int ACC_WIDTH    = 64;                 // M2 accumulator
   localparam int VAR_WIDTH    = ACC_WIDTH - 1;      // reported variance
   localparam int DIV_WIDTH    = ACC_WIDTH;          // divider dividend/quotient
   localparam int STEP_WIDTH   = $clog2(DIV_WIDTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last_sample;
   } omv_req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] mean_value;
      logic [VAR_WIDTH-1:0]           variance_value;
      logic [COUNT_WIDTH-1:0]         sample_total;
      logic                           too_few_flag;
   } omv_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MEAN,
      ST_ERR,
      ST_MUL,
      ST_ACC,
      ST_VAR_LOAD,
      ST_DIV_VAR,
      ST_OUT
   } omv_state_type;

endpackage

`default_nettype wire

[design/online_mean_variance.sv]
// Top level of the Welford online mean/variance block; depends on omv_pkg.
// A sample without the last mark passes through these steps from accept to the next ready:
//   accept, 33 steps of the shared restoring divider (delta / n), mean, error, multiply, add.
// On a last sample the add is followed by these steps up to rsp_valid (a set of one goes straight to output):
//   load, 64 divider steps for M2 / (n-1), output; a held response keeps ready low longer.
// Reset (synchronous, active high) clears count, mean, M2, the sequencer and rsp_valid.
`default_nettype none

module online_mean_variance (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  omv_pkg::omv_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output omv_pkg::omv_rsp_type rsp_payload
);

   localparam int SW  = omv_pkg::SAMPLE_WIDTH;
   localparam int CW  = omv_pkg::COUNT_WIDTH;
   localparam int AW  = omv_pkg::ACC_WIDTH;
   localparam int VW  = omv_pkg::VAR_WIDTH;
   localparam int DW  = omv_pkg::DIV_WIDTH;
   localparam int STW = omv_pkg::STEP_WIDTH;
   localparam int PW  = 2 * (SW + 1);   // full product width of |delta| * |e|
   localparam int XW  = 128;            // headroom for the shift-and-saturate check

   // sequencer
   omv_pkg::omv_state_type state_ff, state_in;

   // set state (Welford accumulators)
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] mean_ff, mean_in;
   logic [AW-1:0] m2_ff, m2_in;

   // current sample
   logic [SW-1:0] x_ff, x_in;
   logic          last_ff, last_in;
   logic          delta_neg_ff, delta_neg_in;
   logic [SW:0]   mag_delta_ff, mag_delta_in;
   logic [SW:0]   mag_e_ff, mag_e_in;
   logic [PW-1:0] prod_ff, prod_in;

   // shared restoring divider: dividend shifts out the top while the
   // quotient shifts in at the bottom of the same register
   logic [DW-1:0]  dvd_ff, dvd_in;
   logic [CW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  dsr_ff, dsr_in;
   logic [STW-1:0] step_ff, step_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   omv_pkg::omv_rsp_type rsp_ff, rsp_in;

   // combinational helpers
   logic [CW:0]   rem_shift, rem_trial;
   logic          rem_ge;
   logic [SW:0]   delta_full, e_full, q_signed, mean_sum;
   logic [XW-1:0] prod_wide;
   logic [AW-1:0] add_sat;
   logic [AW:0]   m2_sum;
   logic [CW-1:0] count_inc;
   logic          too_few;
   logic          out_free;

   assign req_ready   = (state_ff == omv_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= omv_pkg::ST_IDLE;
         count_ff     <= '0;
         mean_ff      <= '0;
         m2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mean_ff      <= mean_in;
         m2_ff        <= m2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      last_ff      <= last_in;
      delta_neg_ff <= delta_neg_in;
      mag_delta_ff <= mag_delta_in;
      mag_e_ff     <= mag_e_in;
      prod_ff      <= prod_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      dsr_ff       <= dsr_in;
      step_ff      <= step_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      // defaults: hold everything
      state_in     = state_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      m2_in        = m2_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      delta_neg_in = delta_neg_ff;
      mag_delta_in = mag_delta_ff;
      mag_e_in     = mag_e_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // one divider step
      rem_shift = {rem_ff, dvd_ff[DW-1]};
      rem_trial = rem_shift - {1'b0, dsr_ff};
      rem_ge    = (rem_shift >= {1'b0, dsr_ff});

      // delta = x - mean, exact in SW+1 bits
      delta_full = {req_payload.sample[SW-1], req_payload.sample} - {mean_ff[SW-1], mean_ff};
      count_inc  = (count_ff == {CW{1'b1}}) ? count_ff : count_ff + CW'(1);

      // mean step: quotient truncated toward zero, sign of delta restored
      q_signed = delta_neg_ff ? (SW+1)'(-dvd_ff[SW:0]) : dvd_ff[SW:0];
      mean_sum = {mean_ff[SW-1], mean_ff} + q_signed;

      // e = x - new mean; same sign as delta, so magnitudes multiply safely
      e_full = {x_ff[SW-1], x_ff} - {mean_ff[SW-1], mean_ff};

      // product back to Q.FRAC_BITS with saturation, then saturating add to M2
      prod_wide = XW'(prod_ff) >> omv_pkg::FRAC_BITS;
      add_sat   = (|prod_wide[XW-1:AW]) ? {AW{1'b1}} : prod_wide[AW-1:0];
      m2_sum    = {1'b0, m2_ff} + {1'b0, add_sat};

      too_few  = (count_ff < CW'(2));
      out_free = !rsp_valid_ff || rsp_ready;

      case (state_ff)
         omv_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in         = req_payload.sample;
               last_in      = req_payload.last_sample;
               count_in     = count_inc;
               delta_neg_in = delta_full[SW];
               mag_delta_in = delta_full[SW] ? (SW+1)'(-delta_full) : delta_full;
               // |delta| left-aligned so its quotient lands in the low SW+1 bits
               dvd_in       = {(delta_full[SW] ? (SW+1)'(-delta_full) : delta_full),
                               {(DW-SW-1){1'b0}}};
               rem_in       = '0;
               dsr_in       = count_inc;
               step_in      = STW'(SW + 1);
               state_in     = omv_pkg::ST_DIV_MEAN;
            end
         end
         omv_pkg::ST_DIV_MEAN, omv_pkg::ST_DIV_VAR: begin
            rem_in  = rem_ge ? rem_trial[CW-1:0] : rem_shift[CW-1:0];
            dvd_in  = {dvd_ff[DW-2:0], rem_ge};
            step_in = step_ff - STW'(1);
            if (step_ff == STW'(1)) begin
               state_in = (state_ff == omv_pkg::ST_DIV_MEAN) ? omv_pkg::ST_MEAN
                                                              : omv_pkg::ST_OUT;
            end
         end
         omv_pkg::ST_MEAN: begin
            mean_in  = mean_sum[SW-1:0];   // stays between old mean and sample
            state_in = omv_pkg::ST_ERR;
         end
         omv_pkg::ST_ERR: begin
            mag_e_in = e_full[SW] ? (SW+1)'(-e_full) : e_full;
            state_in = omv_pkg::ST_MUL;
         end
         omv_pkg::ST_MUL: begin
            prod_in  = PW'(mag_delta_ff) * PW'(mag_e_ff);
            state_in = omv_pkg::ST_ACC;
         end
         omv_pkg::ST_ACC: begin
            m2_in = m2_sum[AW] ? {AW{1'b1}} : m2_sum[AW-1:0];
            if (!last_ff) begin
               state_in = omv_pkg::ST_IDLE;
            end else if (too_few) begin
               state_in = omv_pkg::ST_OUT;
            end else begin
               state_in = omv_pkg::ST_VAR_LOAD;
            end
         end
         omv_pkg::ST_VAR_LOAD: begin
            dvd_in   = DW'(m2_ff);
            rem_in   = '0;
            dsr_in   = count_ff - CW'(1);
            step_in  = STW'(DW);
            state_in = omv_pkg::ST_DIV_VAR;
         end
         omv_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_in.mean_value     = mean_ff;
               rsp_in.sample_total   = count_ff;
               rsp_in.too_few_flag   = too_few;
               if (too_few) begin
                  rsp_in.variance_value = '0;
               end else begin
                  rsp_in.variance_value = dvd_ff[DW-1] ? {VW{1'b1}} : dvd_ff[VW-1:0];
               end
               rsp_valid_in = 1'b1;
               // clear the set for the next one
               count_in     = '0;
               mean_in      = '0;
               m2_in        = '0;
               state_in     = omv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = omv_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/omv_checker.sv]
// Port-level checker for online_mean_variance, bound to the top level.
// Depends on omv_pkg and online_mean_variance_macros.svh.
`default_nettype none
`include "online_mean_variance_macros.svh"

module omv_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input omv_pkg::omv_rsp_type rsp_payload
);

   // a stalled response holds its value
   `OMV_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_payload))

   // block goes busy after taking a request
   `OMV_ASSERT_NEXT(busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // short set: variance forced to zero, total below two
   `OMV_ASSERT_IMP(too_few_zero, clock, reset, rsp_valid && rsp_payload.too_few_flag,
                   rsp_payload.variance_value == '0 &&
                   rsp_payload.sample_total < omv_pkg::COUNT_WIDTH'(2))

   // flag clear means at least two samples were counted
   `OMV_ASSERT_IMP(flag_matches_total, clock, reset, rsp_valid && !rsp_payload.too_few_flag,
                   rsp_payload.sample_total >= omv_pkg::COUNT_WIDTH'(2))

   // no response right after reset
   `OMV_ASSERT_ALWAYS(rsp_idle_after_reset, clock, $past(reset), !rsp_valid)

endmodule

bind online_mean_variance omv_checker u_omv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[verif/tb_online_mean_variance.sv]
`timescale 1ns / 1ps
// Testbench for online_mean_variance: directed and random sample sets are checked
// against a Welford mean/M2 predictor held in a small scoreboard class.
// Depends on omv_pkg and the online_mean_variance RTL.

module tb_online_mean_variance;

   localparam int LONG_HOLD     = 1500;   // receiver back-pressure stretch, in cycles
   localparam int HOLD_AT       = 500;    // request count that triggers it
   localparam int RANDOM_ITEMS  = 1600;
   localparam int DRAIN_CYCLES  = 200;    // settle time after the last response
   localparam int SW            = omv_pkg::SAMPLE_WIDTH;

   typedef enum int {
      SPREAD_FULL, SPREAD_NARROW, SPREAD_FLAT, SPREAD_EXTREME
   } spread_kind_type;

   // Scoreboard: keeps its own count/mean/M2, queues the summary of each set
   // when its last sample is accepted, and compares responses in order.
   class set_stats_board_type;
      localparam logic [omv_pkg::COUNT_WIDTH-1:0] COUNT_CEIL = '1;
      localparam logic [63:0]                     VAR_CEIL   = {1'b0, {63{1'b1}}};

      logic [omv_pkg::COUNT_WIDTH-1:0] samples_in_set;
      longint                          running_mean;
      logic [63:0]                     squared_dev_sum;
      omv_pkg::omv_rsp_type            expected_summaries[$];
      int                              error_count;
      int                              sets_checked;
      int                              short_sets;
      int                              largest_set;

      function new();
         clear_set();
         error_count  = 0;
         sets_checked = 0;
         short_sets   = 0;
         largest_set  = 0;
      endfunction

      function void clear_set();
         samples_in_set  = '0;
         running_mean    = 0;
         squared_dev_sum = '0;
      endfunction

      function logic [63:0] magnitude(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      // Welford step for one accepted request.
      function void note_request(omv_pkg::omv_req_type r);
         longint               x;
         longint               delta;
         longint               err;
         logic [127:0]         prod;
         logic [63:0]          step;
         logic [64:0]          sum;
         logic [63:0]          quot;
         omv_pkg::omv_rsp_type summary;
         x = longint'($signed(r.sample));
         if (samples_in_set != COUNT_CEIL) samples_in_set++;   // count holds at its ceiling
         delta = x - running_mean;
         running_mean = running_mean + delta / longint'(samples_in_set);  // toward zero
         err = x - running_mean;
         // delta and err share a sign: product is exact in Q.32, floored to Q.16
         prod = {64'b0, magnitude(delta)} * {64'b0, magnitude(err)};
         prod = prod >> omv_pkg::FRAC_BITS;
         step = (prod[127:64] != 0) ? '1 : prod[63:0];
         sum = {1'b0, squared_dev_sum} + {1'b0, step};
         squared_dev_sum = sum[64] ? '1 : sum[63:0];
         if (!r.last_sample) return;
         summary.mean_value   = SW'(running_mean);
         summary.sample_total = samples_in_set;
         if (samples_in_set < 2) begin
            summary.variance_value = '0;
            summary.too_few_flag   = 1'b1;
         end else begin
            quot = squared_dev_sum / (64'(samples_in_set) - 64'd1);
            summary.variance_value = (quot > VAR_CEIL) ? VAR_CEIL[62:0] : quot[62:0];
            summary.too_few_flag   = 1'b0;
         end
         expected_summaries.push_back(summary);
         clear_set();
      endfunction

      function void check_result(omv_pkg::omv_rsp_type got);
         omv_pkg::omv_rsp_type want;
         if (expected_summaries.size() == 0) begin
            $error("unexpected response: mean_value %0d sample_total %0d",
                   $signed(got.mean_value), got.sample_total);
            error_count++;
            return;
         end
         want = expected_summaries.pop_front();
         if (got.mean_value !== want.mean_value) begin
            $error("mean_value: expected %0d, actual %0d",
                   $signed(want.mean_value), $signed(got.mean_value));
            error_count++;
         end
         if (got.variance_value !== want.variance_value) begin
            $error("variance_value: expected %0d, actual %0d",
                   want.variance_value, got.variance_value);
            error_count++;
         end
         if (got.sample_total !== want.sample_total) begin
            $error("sample_total: expected %0d, actual %0d",
                   want.sample_total, got.sample_total);
            error_count++;
         end
         if (got.too_few_flag !== want.too_few_flag) begin
            $error("too_few_flag: expected %0d, actual %0d",
                   want.too_few_flag, got.too_few_flag);
            error_count++;
         end
         sets_checked++;
         if (want.too_few_flag) short_sets++;
         if (int'(want.sample_total) > largest_set) largest_set = int'(want.sample_total);
      endfunction

      function int pending();
         return expected_summaries.size();
      endfunction
   endclass

   // Clock, reset and block ports; every input known from time zero.
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   omv_pkg::omv_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   omv_pkg::omv_rsp_type rsp_payload;

   set_stats_board_type board = new();

   int requests_sent = 0;
   int burst_left    = 0;
   bit hold_pending  = 1'b0;
   bit hold_done     = 1'b0;

   always #4 clock = ~clock;

   online_mean_variance u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Monitors: sample both handshakes at the edge where they complete.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
      end
   end

   // Sender: bursts of random length separated by random gaps. Within a burst
   // valid stays high and only the payload changes at each accept edge.
   task automatic send_item(input logic [SW-1:0] value, input bit last);
      omv_pkg::omv_req_type r;
      int                   gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      r.sample      = value;
      r.last_sample = last;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      // one long receiver hold-off while requests keep coming
      if (requests_sent == HOLD_AT && !hold_done) begin
         hold_pending = 1'b1;
         hold_done    = 1'b1;
      end
   endtask

   function automatic logic [SW-1:0] pick_sample(spread_kind_type kind,
                                                 logic [SW-1:0] base);
      case (kind)
         SPREAD_NARROW:  return base + SW'($urandom_range(0, 2047)) - 32'd1024;
         SPREAD_FLAT:    return base;
         SPREAD_EXTREME: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default:        return SW'($urandom);
      endcase
   endfunction

   // One random set; mostly short sets so results stay frequent.
   task automatic send_random_set();
      int              len;
      int              pick;
      spread_kind_type kind;
      logic [SW-1:0]   base;
      pick = $urandom_range(0, 99);
      if (pick < 15)      len = 1;
      else if (pick < 80) len = $urandom_range(2, 6);
      else if (pick < 95) len = $urandom_range(7, 30);
      else                len = $urandom_range(31, 60);
      kind = spread_kind_type'($urandom_range(0, 3));
      base = SW'($urandom);
      for (int i = 0; i < len; i++)
         send_item(pick_sample(kind, base), i == len - 1);
   endtask

   // Receiver: ready follows a rotating 16-bit pattern that is re-chosen after each
   // run of random length (all-ready stretches included), plus one long hold.
   initial begin : receiver
      logic [15:0] pattern;
      int          run_left;
      pattern  = '1;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (run_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       pattern = 16'hFFFF;
                  1:       pattern = 16'($urandom);
                  2:       pattern = 16'h0101;
                  default: pattern = 16'hFFF0;
               endcase
               run_left = $urandom_range(40, 400);
            end
            rsp_ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
            run_left--;
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single-sample sets at the extremes: variance 0, flag set
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h8000_0000, 1'b1);
      send_item(32'h0000_0000, 1'b1);
      // two-sample sets spanning the full range, both orders
      send_item(32'h8000_0000, 1'b0);
      send_item(32'h7FFF_FFFF, 1'b1);
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b1);
      // alternating bit patterns
      send_item(32'hAAAA_AAAA, 1'b0);
      send_item(32'h5555_5555, 1'b0);
      send_item(32'h0000_0000, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b1);
      // constant set: zero variance
      send_item(32'h0001_0000, 1'b0);
      send_item(32'h0001_0000, 1'b0);
      send_item(32'h0001_0000, 1'b1);
      // tiny values around zero, then a jump to the minimum
      send_item(32'h0000_0001, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h0000_0001, 1'b0);
      send_item(32'hFFFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b1);

      while (requests_sent < RANDOM_ITEMS) send_random_set();
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests in %0d sets (%0d with fewer than two samples,",
               requests_sent, board.sets_checked, board.short_sets);
      $display("  largest set %0d samples), with one long response hold-off",
               board.largest_set);
      if (board.error_count == 0) begin
         $display("[online_mean_variance] OK");
      end else begin
         $display("[online_mean_variance] ERROR");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin : watchdog
      #20000000;
      $display("[online_mean_variance] ERROR");
      $finish;
   end

endmodule
